// ===== src/lru_page_replacement_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lru check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lru check failed");

`endif

// ===== src/lru_pkg.sv =====
package lru_pkg;

	localparam int CFG_W   = 5;
	localparam int COUNT_W = 32;

	localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

	// register indexes on the configuration port
	localparam logic REG_ACTIVE_FRAMES = 1'b0;

	typedef struct packed {
		logic update;   // a reference is accepted this cycle
		logic active;   // cell lies inside the active frames
	} lru_cell_ctrl_t;

endpackage

// ===== src/lru_cell.sv =====
module lru_cell #(
	parameter int PAGE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lru_pkg::lru_cell_ctrl_t    ctrl,
	input  logic [PAGE_BITS-1:0]       lookup_page,
	input  logic [PAGE_BITS-1:0]       prev_page,
	input  logic                       prev_valid,
	input  logic                       found_in,
	output logic [PAGE_BITS-1:0]       page_q,
	output logic                       valid_q,
	output logic                       found_out
);

	logic match;
	logic load;

	assign match     = valid_q && (page_q == lookup_page);
	// shift from the neighbour unless the page was found nearer the front
	assign load      = ctrl.update && ctrl.active && !found_in;
	assign found_out = found_in || (ctrl.active && match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			page_q <= prev_page;
		end
	end

endmodule

// ===== src/lru_page_replacement_top.sv =====
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    page_number
// m_*      out  m_tvalid/m_tready    is_fault, evicted_valid, evicted_page, fault_total
// apb      in   psel/penable/pready  active_frames at byte address 0
//
// One reference is taken per cycle while s_tready is high; the lookup, the recency
// shift and the eviction all settle in the single cycle of the accepting edge.
// The result sits in an output register; a new reference is taken while it
// is being drained, so a stall on m_tready holds s_tready low only for as
// long as the held result is not taken.
// arst_n clears the frame valid bits, the fault count and the output valid;
// active_frames returns to 4.
module lru_page_replacement_top #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16,
	localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((PAGE_BITS + 2 + lru_pkg::COUNT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// reference stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // page_number
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // is_fault, evicted_valid, evicted_page, fault_total
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [lru_pkg::CFG_W-1:0] active_frames_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_frames_q <= lru_pkg::FRAMES_RESET;
		end else if (cfg_wr && (paddr[2] == lru_pkg::REG_ACTIVE_FRAMES)) begin
			active_frames_q <= pwdata[lru_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			lru_pkg::REG_ACTIVE_FRAMES: prdata = 32'(active_frames_q);
			default:                    prdata = '0;
		endcase
	end

	// Position of the least recent active frame: clamp the count to
	// 1..MAX_FRAMES, then step back by one.
	logic [IDX_W-1:0] last_idx;

	always_comb begin
		if (active_frames_q == '0) begin
			last_idx = '0;
		end else if (32'(active_frames_q) > MAX_FRAMES) begin
			last_idx = IDX_W'(MAX_FRAMES - 1);
		end else begin
			last_idx = IDX_W'(active_frames_q - 5'd1);
		end
	end

	// ---------------------------------------------------------------
	// Handshake: advance whenever the output register is free or drains
	// ---------------------------------------------------------------
	logic accept;
	logic m_valid_q;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	logic [PAGE_BITS-1:0] lookup_page;
	assign lookup_page = s_tdata[PAGE_BITS-1:0];

	// ---------------------------------------------------------------
	// Recency chain: cell 0 is the most recent. Each cell takes its
	// neighbour's entry until the hit cell has been passed; cell 0 takes
	// the referenced page. The hit flag ripples down the chain.
	// ---------------------------------------------------------------
	logic [PAGE_BITS-1:0] cell_page  [MAX_FRAMES];
	logic                 cell_valid [MAX_FRAMES];
	logic [MAX_FRAMES:0]  found;

	assign found[0] = 1'b0;

	for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
		lru_pkg::lru_cell_ctrl_t ctrl;
		logic [PAGE_BITS-1:0]    prev_page;
		logic                    prev_valid;

		assign ctrl = '{update: accept, active: (IDX_W'(k) <= last_idx)};

		if (k == 0) begin : g_head
			assign prev_page  = lookup_page;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_page  = cell_page[k-1];
			assign prev_valid = cell_valid[k-1];
		end

		lru_cell #(
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.lookup_page (lookup_page),
			.prev_page   (prev_page),
			.prev_valid  (prev_valid),
			.found_in    (found[k]),
			.page_q      (cell_page[k]),
			.valid_q     (cell_valid[k]),
			.found_out   (found[k+1])
		);
	end

	// ---------------------------------------------------------------
	// Result: a miss pushes out the last active cell and counts a fault
	// ---------------------------------------------------------------
	logic                         miss;
	logic                         ev_valid;
	logic [PAGE_BITS-1:0]         ev_page;
	logic [lru_pkg::COUNT_W-1:0]  count_q;
	logic [lru_pkg::COUNT_W-1:0]  count_nxt;

	assign miss     = !found[MAX_FRAMES];
	assign ev_valid = miss && cell_valid[last_idx];
	assign ev_page  = ev_valid ? cell_page[last_idx] : '0;

	always_comb begin
		count_nxt = count_q;
		if (miss && (count_q != lru_pkg::COUNT_MAX)) begin
			count_nxt = count_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until the transaction completes
	logic                         fault_q;
	logic                         ev_valid_q;
	logic [PAGE_BITS-1:0]         ev_page_q;
	logic [lru_pkg::COUNT_W-1:0]  total_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			fault_q    <= miss;
			ev_valid_q <= ev_valid;
			ev_page_q  <= ev_page;
			total_q    <= count_nxt;
		end
	end

	assign m_tdata = OUT_W'({total_q, ev_page_q, ev_valid_q, fault_q});

endmodule

// ===== src/lru_checker.sv =====
`include "lru_page_replacement_top_macros.svh"

module lru_checker #(
	parameter int PAGE_BITS = 16,
	localparam int OUT_W = ((PAGE_BITS + 2 + lru_pkg::COUNT_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic                 is_fault;
	logic                 ev_valid;
	logic [PAGE_BITS-1:0] ev_page;
	logic [31:0]          total;

	assign is_fault = m_tdata[0];
	assign ev_valid = m_tdata[1];
	assign ev_page  = m_tdata[PAGE_BITS+1:2];
	assign total    = m_tdata[PAGE_BITS+33:PAGE_BITS+2];

	// input stalls only behind a held result
	`LRU_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	// a stalled result holds
	`LRU_ASSERT_NEXT(a_hold_result, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// eviction only on a fault, and an empty eviction reads zero
	`LRU_ASSERT_NOW(a_evict_on_fault, clk, arst_n, m_tvalid && ev_valid, is_fault)
	`LRU_ASSERT_NOW(a_empty_evict_zero, clk, arst_n, m_tvalid && !ev_valid, ev_page == '0)
	// a fault always leaves a non-zero count
	`LRU_ASSERT_NOW(a_fault_counted, clk, arst_n, m_tvalid && is_fault, total != 32'd0)

endmodule

bind lru_page_replacement_top lru_checker #(
	.PAGE_BITS (PAGE_BITS)
) u_lru_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
